[hw/rtl/vlfm_pkg.sv]
package vlfm_pkg;

  // descriptor slots, one bit per possible descriptor in emission order
  localparam int unsigned NumSlots = 34;
  localparam int unsigned SlotW    = 6;
  localparam int unsigned MaskW    = 32;

  typedef logic [NumSlots-1:0] slot_vec_t;
  typedef logic [SlotW-1:0]    slot_idx_t;

  // slot ranges
  localparam slot_idx_t SlotTexFirst = 6'd10;
  localparam slot_idx_t SlotTexLast  = 6'd25;
  localparam slot_idx_t SlotUnkFirst = 6'd26;
  localparam slot_idx_t SlotUnkLast  = 6'd28;

  // semantic codes
  localparam logic [3:0] SemPosition     = 4'd0;
  localparam logic [3:0] SemBlendWeight  = 4'd1;
  localparam logic [3:0] SemBlendIndices = 4'd2;
  localparam logic [3:0] SemNormal       = 4'd3;
  localparam logic [3:0] SemColor        = 4'd4;
  localparam logic [3:0] SemTangent      = 4'd5;
  localparam logic [3:0] SemBinormal     = 4'd6;
  localparam logic [3:0] SemTexcoord     = 4'd7;
  localparam logic [3:0] SemUnknownOne   = 4'd8;
  localparam logic [3:0] SemUnknownTwo   = 4'd9;
  localparam logic [3:0] SemUnknownThree = 4'd10;
  localparam logic [3:0] SemUnknownFour  = 4'd11;
  localparam logic [3:0] SemUnknownFive  = 4'd12;

  // format codes
  localparam logic [2:0] FmtRgb32f      = 3'd0;
  localparam logic [2:0] FmtRgba8Unorm  = 3'd1;
  localparam logic [2:0] FmtRgba8Uint   = 3'd2;
  localparam logic [2:0] FmtRg32f       = 3'd3;
  localparam logic [2:0] FmtRg16f       = 3'd4;
  localparam logic [2:0] FmtRgba32f     = 3'd5;
  localparam logic [2:0] FmtR32f        = 3'd6;
  localparam logic [2:0] FmtR11g11b10f  = 3'd7;

  // semantic of each slot
  function automatic logic [3:0] slot_sem(slot_idx_t idx);
    logic [3:0] sem;
    case (idx)
      6'd0:    sem = SemPosition;
      6'd1:    sem = SemBlendWeight;
      6'd2:    sem = SemBlendIndices;
      6'd3:    sem = SemNormal;
      6'd4:    sem = SemColor;
      6'd5:    sem = SemTangent;
      6'd6:    sem = SemBinormal;
      6'd7:    sem = SemNormal;
      6'd8:    sem = SemTangent;
      6'd9:    sem = SemBinormal;
      6'd26, 6'd27, 6'd28: sem = SemUnknownOne;
      6'd29:   sem = SemUnknownTwo;
      6'd30:   sem = SemUnknownThree;
      6'd31:   sem = SemUnknownFour;
      6'd32:   sem = SemPosition;
      6'd33:   sem = SemUnknownFive;
      default: sem = SemTexcoord;
    endcase
    return sem;
  endfunction

  // format of each slot
  function automatic logic [2:0] slot_fmt(slot_idx_t idx);
    logic [2:0] fmt;
    case (idx)
      6'd0, 6'd3, 6'd5, 6'd6, 6'd33: fmt = FmtRgb32f;
      6'd1, 6'd4, 6'd7, 6'd8, 6'd9:  fmt = FmtRgba8Unorm;
      6'd2:                          fmt = FmtRgba8Uint;
      6'd26, 6'd27, 6'd28, 6'd31:    fmt = FmtRgba32f;
      6'd29, 6'd30:                  fmt = FmtR32f;
      6'd32:                         fmt = FmtR11g11b10f;
      default: begin
        if (idx inside {[6'd10:6'd17]}) begin
          fmt = FmtRg32f;
        end else begin
          fmt = FmtRg16f;
        end
      end
    endcase
    return fmt;
  endfunction

  // size in bytes of each format
  function automatic logic [4:0] fmt_bytes(logic [2:0] fmt);
    logic [4:0] sz;
    case (fmt)
      FmtRgb32f:  sz = 5'd12;
      FmtRg32f:   sz = 5'd8;
      FmtRgba32f: sz = 5'd16;
      default:    sz = 5'd4;
    endcase
    return sz;
  endfunction

endpackage

[hw/rtl/vlfm_front.sv]
module vlfm_front (
  input  logic [vlfm_pkg::MaskW-1:0] format_mask_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  output logic                       push_o,
  output vlfm_pkg::slot_vec_t        slots_o,
  input  logic                       full_i
);

  // expand flag mask into one bit per descriptor slot
  always_comb begin
    slots_o        = '0;
    slots_o[6:0]   = format_mask_i[6:0];
    slots_o[9:7]   = {3{format_mask_i[7]}};
    slots_o[25:10] = format_mask_i[23:8];
    slots_o[28:26] = {3{format_mask_i[24]}};
    slots_o[33:29] = format_mask_i[29:25];
  end

  // accept whenever the queue has room
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

[hw/rtl/vlfm_queue.sv]
module vlfm_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  vlfm_pkg::slot_vec_t wdata_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                pop_i,
  output vlfm_pkg::slot_vec_t rdata_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  vlfm_pkg::slot_vec_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[hw/rtl/vlfm_back.sv]
module vlfm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  vlfm_pkg::slot_vec_t q_data_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                element_valid_o,
  output logic [3:0]          semantic_o,
  output logic [3:0]          semantic_index_o,
  output logic [2:0]          element_format_o,
  output logic [7:0]          byte_offset_o,
  output logic [8:0]          vertex_stride_o,
  output logic                last_o
);

  logic                have_q, have_d;
  vlfm_pkg::slot_vec_t cur_q, cur_d;
  logic [8:0]          off_q, off_d;
  logic [3:0]          tc_q, tc_d;
  logic                out_valid_q, out_valid_d;

  logic                found;
  vlfm_pkg::slot_idx_t idx;
  vlfm_pkg::slot_vec_t rest;
  logic [3:0]          sem_w, sidx_w;
  logic [2:0]          fmt_w;
  logic [4:0]          size_w;
  logic [8:0]          next_off;
  logic                is_tex, is_unk, last_w;
  logic                load_en, emit, finish;

  // lowest pending slot
  always_comb begin
    idx = '0;
    for (int i = vlfm_pkg::NumSlots - 1; i >= 0; i--) begin
      if (cur_q[i]) begin
        idx = vlfm_pkg::SlotW'(i);
      end
    end
  end

  assign found = |cur_q;
  assign rest  = cur_q & ~(vlfm_pkg::slot_vec_t'(1) << idx);

  // descriptor fields for the current slot
  always_comb begin
    is_tex   = idx inside {[vlfm_pkg::SlotTexFirst:vlfm_pkg::SlotTexLast]};
    is_unk   = idx inside {[vlfm_pkg::SlotUnkFirst:vlfm_pkg::SlotUnkLast]};
    sem_w    = vlfm_pkg::slot_sem(idx);
    fmt_w    = vlfm_pkg::slot_fmt(idx);
    size_w   = vlfm_pkg::fmt_bytes(fmt_w);
    next_off = off_q + {4'd0, size_w};
    if (is_tex) begin
      sidx_w = tc_q;
    end else if (is_unk) begin
      sidx_w = 4'(idx - vlfm_pkg::SlotUnkFirst);
    end else begin
      sidx_w = '0;
    end
    last_w = !found || (rest == '0);
  end

  // serializer control
  assign load_en = !out_valid_q || !out_stall_i;
  assign emit    = have_q && load_en;
  assign finish  = emit && last_w;
  assign q_pop_o = q_valid_i && (!have_q || finish);

  always_comb begin
    have_d      = have_q;
    cur_d       = cur_q;
    off_d       = off_q;
    tc_d        = tc_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (load_en) begin
      out_valid_d = 1'b0;
    end
    if (q_pop_o) begin
      have_d = 1'b1;
      cur_d  = q_data_i;
      off_d  = '0;
      tc_d   = '0;
    end else if (finish) begin
      have_d = 1'b0;
    end else if (emit) begin
      cur_d = rest;
      off_d = next_off;
      tc_d  = is_tex ? tc_q + 1'b1 : tc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    off_q <= off_d;
    tc_q  <= tc_d;
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      element_valid_o  <= found;
      semantic_o       <= found ? sem_w : '0;
      semantic_index_o <= found ? sidx_w : '0;
      element_format_o <= found ? fmt_w : '0;
      byte_offset_o    <= found ? off_q[7:0] : '0;
      vertex_stride_o  <= (found && last_w) ? next_off : '0;
      last_o           <= last_w;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/vertex_layout_from_flag_mask_core.sv]
// Vertex layout builder: each accepted 32-bit format mask produces its vertex
// attribute descriptors, one per cycle while out_stall_i is low, in fixed
// order (fixed attributes, tangent frame, texcoords, extra entries), each
// with semantic, index, format and byte offset; the final one has last set
// and carries the vertex stride. A mask with bits 0 to 29 clear yields a
// single descriptor with element_valid low and last high. An item has 1 to
// 34 descriptors and holds the serializer until all are out; that single
// serializer sets the throughput. A queue of QueueDepth masks (at least 2)
// sits in front, so new masks are accepted while earlier ones are still
// in the serializer, which moves on to the next mask without a gap cycle.
module vertex_layout_from_flag_mask_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] format_mask_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        element_valid_o,
  output logic [3:0]  semantic_o,
  output logic [3:0]  semantic_index_o,
  output logic [2:0]  element_format_o,
  output logic [7:0]  byte_offset_o,
  output logic [8:0]  vertex_stride_o,
  output logic        last_o
);

  logic                push, full, q_valid, q_pop;
  vlfm_pkg::slot_vec_t slots, q_data;

  // mask classification and input acceptance
  vlfm_front u_front (
    .format_mask_i (format_mask_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .push_o        (push),
    .slots_o       (slots),
    .full_i        (full)
  );

  // decoupling queue
  vlfm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (slots),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .rdata_o (q_data)
  );

  // descriptor serializer
  vlfm_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_data_i         (q_data),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .element_valid_o  (element_valid_o),
    .semantic_o       (semantic_o),
    .semantic_index_o (semantic_index_o),
    .element_format_o (element_format_o),
    .byte_offset_o    (byte_offset_o),
    .vertex_stride_o  (vertex_stride_o),
    .last_o           (last_o)
  );

endmodule
